FILE: hdl/mcsw_pkg.sv
// ----------------------------------------------------------------------------
// mcsw_pkg - watchdog bank shared definitions
// Widths, command codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcsw_pkg;

	localparam int CHANNELS    = 4;
	localparam int COUNT_BITS  = 16;
	localparam int NUM_RELOAD  = 4;
	localparam int RELOAD_BITS = 16;
	localparam int MASK_BITS   = 4;
	localparam int MODE_BITS   = 3;
	localparam int CH_BITS     = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_TICK    = 3'd0,
		MODE_FEED    = 3'd1,
		MODE_ARM     = 3'd2,
		MODE_DISARM  = 3'd3,
		MODE_ENABLE  = 3'd4,
		MODE_DISABLE = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_RELOAD0 = 3'd0,
		CFG_RELOAD1 = 3'd1,
		CFG_RELOAD2 = 3'd2,
		CFG_RELOAD3 = 3'd3,
		CFG_ALARM   = 3'd4
	} cfg_idx_t;

	typedef logic [NUM_RELOAD-1:0][RELOAD_BITS-1:0] reload_arr_t;

	typedef struct packed {
		logic [MASK_BITS-1:0] expired;
		logic [MASK_BITS-1:0] online;
		logic                 rejected;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/multi_channel_soft_watchdog.sv
// Latency: a result is shown in the cycle after its transfer is accepted, unless an earlier result is stalled.
// Throughput: one item per cycle while in_stall is low; the channel bank registers update on each accepted item.
// A skid stage behind the result register lets one more item be accepted while the output is stalled.
// Reset (arst_n low) clears counts, armed and enabled flags, configuration and buffers.
// ----------------------------------------------------------------------------
// multi_channel_soft_watchdog - four-channel watchdog bank
// Tick, feed, arm, disarm, enable and disable commands with expiry reporting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_soft_watchdog (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mcsw_pkg::MODE_BITS-1:0]     mode,
	input  wire logic [mcsw_pkg::CH_BITS-1:0]       channel,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mcsw_pkg::MASK_BITS-1:0]          expired_mask,
	output logic [mcsw_pkg::MASK_BITS-1:0]          online_mask,
	output logic                                   rejected,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mcsw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [mcsw_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	mcsw_pkg::reload_arr_t          reload;
	logic [mcsw_pkg::MASK_BITS-1:0] alarm_mask;
	mcsw_pkg::res_t                 step_res;
	mcsw_pkg::res_t                 out_res;
	logic                           buf_full;
	logic                           accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign accept    = in_valid && !buf_full;

	mcsw_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && cfg_ready),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.reload     (reload),
		.alarm_mask (alarm_mask)
	);

	mcsw_bank u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.channel    (channel),
		.reload     (reload),
		.alarm_mask (alarm_mask),
		.res        (step_res)
	);

	mcsw_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign expired_mask = out_res.expired;
	assign online_mask  = out_res.online;
	assign rejected     = out_res.rejected;

endmodule

`default_nettype wire

FILE: hdl/mcsw_cfg.sv
// ----------------------------------------------------------------------------
// mcsw_cfg - configuration registers
// Reload values for each channel and the alarm enable mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsw_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [mcsw_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [mcsw_pkg::CFG_DATA_BITS-1:0] wr_data,
	output mcsw_pkg::reload_arr_t                  reload,
	output logic [mcsw_pkg::MASK_BITS-1:0]          alarm_mask
);

	mcsw_pkg::reload_arr_t             reload_q;
	logic [mcsw_pkg::MASK_BITS-1:0]    alarm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			alarm_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mcsw_pkg::CFG_RELOAD0: reload_q[0] <= wr_data[mcsw_pkg::RELOAD_BITS-1:0];
				mcsw_pkg::CFG_RELOAD1: reload_q[1] <= wr_data[mcsw_pkg::RELOAD_BITS-1:0];
				mcsw_pkg::CFG_RELOAD2: reload_q[2] <= wr_data[mcsw_pkg::RELOAD_BITS-1:0];
				mcsw_pkg::CFG_RELOAD3: reload_q[3] <= wr_data[mcsw_pkg::RELOAD_BITS-1:0];
				mcsw_pkg::CFG_ALARM:   alarm_q     <= wr_data[mcsw_pkg::MASK_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign reload     = reload_q;
	assign alarm_mask = alarm_q;

endmodule

`default_nettype wire

FILE: hdl/mcsw_bank.sv
// ----------------------------------------------------------------------------
// mcsw_bank - watchdog channel bank
// Holds count, armed and enabled per channel; applies one accepted command per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsw_bank (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic [mcsw_pkg::MODE_BITS-1:0]   mode,
	input  wire logic [mcsw_pkg::CH_BITS-1:0]     channel,
	input  wire mcsw_pkg::reload_arr_t           reload,
	input  wire logic [mcsw_pkg::MASK_BITS-1:0]   alarm_mask,
	output mcsw_pkg::res_t                       res
);

	logic [mcsw_pkg::COUNT_BITS-1:0] count_q [mcsw_pkg::CHANNELS];
	logic [mcsw_pkg::CHANNELS-1:0]   armed_q;
	logic [mcsw_pkg::CHANNELS-1:0]   enabled_q;

	logic [mcsw_pkg::COUNT_BITS-1:0] count_d [mcsw_pkg::CHANNELS];
	logic [mcsw_pkg::CHANNELS-1:0]   armed_d;
	logic [mcsw_pkg::CHANNELS-1:0]   enabled_d;
	logic [mcsw_pkg::CHANNELS-1:0]   sel;
	logic                            live;

	always_comb begin
		for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
			sel[i] = (channel == mcsw_pkg::CH_BITS'(i));
		end
		live = |(sel & enabled_q);
	end

	always_comb begin
		count_d   = count_q;
		armed_d   = armed_q;
		enabled_d = enabled_q;
		res       = '0;
		case (mode)
			mcsw_pkg::MODE_TICK: begin
				for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
					if (enabled_q[i]) begin
						if (count_q[i] != '0)
							count_d[i] = count_q[i] - mcsw_pkg::COUNT_BITS'(1);
						else if (armed_q[i] && alarm_mask[i])
							res.expired[i] = 1'b1;
					end
				end
			end
			mcsw_pkg::MODE_FEED: begin
				res.rejected = !live;
				for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
					if (sel[i] && enabled_q[i])
						count_d[i] = mcsw_pkg::COUNT_BITS'(reload[i]);
				end
			end
			mcsw_pkg::MODE_ARM: begin
				res.rejected = !live;
				armed_d      = armed_q | (sel & enabled_q);
			end
			mcsw_pkg::MODE_DISARM: begin
				res.rejected = !live;
				armed_d      = armed_q & ~(sel & enabled_q);
			end
			mcsw_pkg::MODE_ENABLE: begin
				for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
					if (sel[i] && !enabled_q[i]) begin
						enabled_d[i] = 1'b1;
						armed_d[i]   = 1'b0;
						count_d[i]   = '0;
					end
				end
			end
			mcsw_pkg::MODE_DISABLE: begin
				for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
					if (sel[i]) begin
						enabled_d[i] = 1'b0;
						armed_d[i]   = 1'b0;
						count_d[i]   = '0;
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
			res.online[i] = (count_d[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
				count_q[i] <= '0;
			end
			armed_q   <= '0;
			enabled_q <= '0;
		end else if (accept) begin
			count_q   <= count_d;
			armed_q   <= armed_d;
			enabled_q <= enabled_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/mcsw_out_buf.sv
// ----------------------------------------------------------------------------
// mcsw_out_buf - result register with skid stage
// Two-entry output buffer; upstream stall is taken from the skid flag only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsw_out_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mcsw_pkg::res_t push_data,
	output logic                full,
	output logic                out_valid,
	input  wire logic           out_stall,
	output mcsw_pkg::res_t      out_data
);

	logic           main_valid_q;
	logic           skid_valid_q;
	mcsw_pkg::res_t main_q;
	mcsw_pkg::res_t skid_q;
	logic           pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else if (!push)
				main_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			if (main_valid_q)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire

FILE: hdl/mcsw_checker.sv
// ----------------------------------------------------------------------------
// mcsw_checker - port-level checks for the watchdog bank
// Bound to the top level; watches handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcsw_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [mcsw_pkg::MASK_BITS-1:0] expired_mask,
	input wire logic [mcsw_pkg::MASK_BITS-1:0] online_mask,
	input wire logic                          rejected
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> out_valid)
		else $error("accepted transfer did not reach output");

	a_expired_offline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((expired_mask & online_mask) == '0))
		else $error("expired channel reported online");

	a_reject_no_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> (expired_mask == '0))
		else $error("rejected command reported expiry");

endmodule

bind multi_channel_soft_watchdog mcsw_checker u_mcsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.expired_mask (expired_mask),
	.online_mask  (online_mask),
	.rejected     (rejected)
);

`default_nettype wire

FILE: tb/multi_channel_soft_watchdog_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_soft_watchdog_test - watchdog bank testbench
// Drives ticks and channel commands through four idle and stall phases. Each accepted
// command is run through a behavioural copy of the bank, and every status
// transfer is compared field by field with the oldest predicted status.
// ----------------------------------------------------------------------------

module multi_channel_soft_watchdog_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [mcsw_pkg::MODE_BITS-1:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [mcsw_pkg::MODE_BITS-1:0] MODE_UNUSED_HI = 3'd7;

	class watchdog_bank_model;
		logic [mcsw_pkg::COUNT_BITS-1:0]  count [mcsw_pkg::CHANNELS];
		bit                               armed [mcsw_pkg::CHANNELS];
		bit                               enabled [mcsw_pkg::CHANNELS];
		logic [mcsw_pkg::RELOAD_BITS-1:0] reload [mcsw_pkg::NUM_RELOAD];
		logic [mcsw_pkg::MASK_BITS-1:0]   alarm_mask;
		mcsw_pkg::res_t                   expected_status [$];
		int                               mismatches;

		function new();
			foreach (count[i]) begin
				count[i] = '0;
				armed[i] = 1'b0;
				enabled[i] = 1'b0;
			end
			foreach (reload[i])
				reload[i] = '0;
			alarm_mask = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [mcsw_pkg::CFG_IDX_BITS-1:0] idx,
				logic [mcsw_pkg::CFG_DATA_BITS-1:0] data);
			case (idx)
			mcsw_pkg::CFG_RELOAD0, mcsw_pkg::CFG_RELOAD1,
			mcsw_pkg::CFG_RELOAD2, mcsw_pkg::CFG_RELOAD3: reload[idx[1:0]] = data;
			mcsw_pkg::CFG_ALARM: alarm_mask = data[mcsw_pkg::MASK_BITS-1:0];
			default: ;
			endcase
		endfunction

		function void note_command(logic [mcsw_pkg::MODE_BITS-1:0] m,
				logic [mcsw_pkg::CH_BITS-1:0] c);
			mcsw_pkg::res_t status;
			status = '0;
			case (m)
			mcsw_pkg::MODE_TICK: begin
				for (int i = 0; i < mcsw_pkg::CHANNELS; i++) begin
					if (enabled[i]) begin
						if (count[i] != 0)
							count[i] = count[i] - 1'b1;
						else if (armed[i] && alarm_mask[i])
							status.expired[i] = 1'b1;
					end
				end
			end
			mcsw_pkg::MODE_FEED: begin
				if (enabled[c])
					count[c] = reload[c];
				else
					status.rejected = 1'b1;
			end
			mcsw_pkg::MODE_ARM, mcsw_pkg::MODE_DISARM: begin
				if (enabled[c])
					armed[c] = (m == mcsw_pkg::MODE_ARM);
				else
					status.rejected = 1'b1;
			end
			mcsw_pkg::MODE_ENABLE: begin
				if (!enabled[c]) begin
					enabled[c] = 1'b1;
					armed[c] = 1'b0;
					count[c] = '0;
				end
			end
			mcsw_pkg::MODE_DISABLE: begin
				enabled[c] = 1'b0;
				armed[c] = 1'b0;
				count[c] = '0;
			end
			default: ;
			endcase
			for (int i = 0; i < mcsw_pkg::CHANNELS; i++)
				status.online[i] = (count[i] != 0);
			expected_status.push_back(status);
		endfunction

		function void check_status(mcsw_pkg::res_t got);
			mcsw_pkg::res_t want;
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected status transfer exp=%h onl=%h rej=%b",
						$realtime, got.expired, got.online, got.rejected);
				return;
			end
			want = expected_status.pop_front();
			if (got.expired !== want.expired || got.online !== want.online ||
					got.rejected !== want.rejected) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: status mismatch: expected exp=%h onl=%h rej=%b, ",
						"got exp=%h onl=%h rej=%b"},
						$realtime, want.expired, want.online, want.rejected,
						got.expired, got.online, got.rejected);
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic [mcsw_pkg::MODE_BITS-1:0]     mode = '0;
	logic [mcsw_pkg::CH_BITS-1:0]       channel = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic [mcsw_pkg::MASK_BITS-1:0]     expired_mask;
	logic [mcsw_pkg::MASK_BITS-1:0]     online_mask;
	logic                               rejected;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [mcsw_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [mcsw_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	watchdog_bank_model bank;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;
	int unsigned cycles = 0;

	multi_channel_soft_watchdog DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.channel      (channel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.expired_mask (expired_mask),
		.online_mask  (online_mask),
		.rejected     (rejected),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// status side: check on transfer, then decide next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			bank.check_status({expired_mask, online_mask, rejected});
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic send_command(logic [mcsw_pkg::MODE_BITS-1:0] m,
			logic [mcsw_pkg::CH_BITS-1:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		channel <= c;
		do @(posedge clk); while (in_stall);
		bank.note_command(m, c);
	endtask

	task automatic random_command(output bit counted);
		int pick;
		logic [mcsw_pkg::MODE_BITS-1:0] m;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			m = mcsw_pkg::MODE_TICK;
		else if (pick < 60)
			m = mcsw_pkg::MODE_FEED;
		else if (pick < 72)
			m = mcsw_pkg::MODE_ARM;
		else if (pick < 77)
			m = mcsw_pkg::MODE_DISARM;
		else if (pick < 90)
			m = mcsw_pkg::MODE_ENABLE;
		else if (pick < 96)
			m = mcsw_pkg::MODE_DISABLE;
		else
			m = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
		counted = (pick < 96);
		send_command(m, mcsw_pkg::CH_BITS'($urandom_range(0, mcsw_pkg::CHANNELS - 1)));
	endtask

	task automatic run_random(int n);
		int done;
		bit counted;
		done = 0;
		while (done < n) begin
			random_command(counted);
			if (counted)
				done++;
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (bank.expected_status.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(mcsw_pkg::cfg_idx_t idx,
			logic [mcsw_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		bank.write_reg(idx, data);
	endtask

	task automatic program_bank(logic [15:0] r0, logic [15:0] r1, logic [15:0] r2,
			logic [15:0] r3, logic [mcsw_pkg::MASK_BITS-1:0] alarm);
		write_reg(mcsw_pkg::CFG_RELOAD0, r0);
		write_reg(mcsw_pkg::CFG_RELOAD1, r1);
		write_reg(mcsw_pkg::CFG_RELOAD2, r2);
		write_reg(mcsw_pkg::CFG_RELOAD3, r3);
		write_reg(mcsw_pkg::CFG_ALARM,
			{{(mcsw_pkg::CFG_DATA_BITS-mcsw_pkg::MASK_BITS){1'b0}}, alarm});
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_commands();
		// commands to channels not yet enabled, idle tick, unused modes
		send_command(mcsw_pkg::MODE_FEED, 2'd0);
		send_command(mcsw_pkg::MODE_ARM, 2'd1);
		send_command(mcsw_pkg::MODE_DISARM, 2'd2);
		send_command(mcsw_pkg::MODE_TICK, 2'd3);
		send_command(mcsw_pkg::MODE_DISABLE, 2'd3);
		send_command(MODE_UNUSED_LO, 2'd1);
		send_command(MODE_UNUSED_HI, 2'd2);
		for (int i = 0; i < mcsw_pkg::CHANNELS; i++)
			send_command(mcsw_pkg::MODE_ENABLE, mcsw_pkg::CH_BITS'(i));
		send_command(mcsw_pkg::MODE_ENABLE, 2'd1);
		for (int i = 0; i < mcsw_pkg::CHANNELS; i++)
			send_command(mcsw_pkg::MODE_FEED, mcsw_pkg::CH_BITS'(i));
		send_command(mcsw_pkg::MODE_ARM, 2'd0);
		send_command(mcsw_pkg::MODE_ARM, 2'd1);
		send_command(mcsw_pkg::MODE_ARM, 2'd2);
		// channel 1 reaches zero, expires only on the following tick
		send_command(mcsw_pkg::MODE_TICK, 2'd0);
		send_command(mcsw_pkg::MODE_TICK, 2'd3);
		send_command(mcsw_pkg::MODE_DISARM, 2'd1);
		send_command(mcsw_pkg::MODE_TICK, 2'd1);
		send_command(mcsw_pkg::MODE_DISABLE, 2'd2);
		send_command(mcsw_pkg::MODE_TICK, 2'd2);
	endtask

	initial begin
		bank = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				program_bank(16'd0, 16'd1, 16'd2, 16'hFFFF, 4'hF);
				directed_commands();
				run_random(150);
				// long output hold-off while commands keep coming
				hold_left = 80;
				run_random(170);
			end
			1: begin
				send_idle_pct = 86;
				recv_stall_pct = 0;
				program_bank(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)), 4'h0);
				run_random(320);
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 86;
				program_bank(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
					16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
					mcsw_pkg::MASK_BITS'($urandom_range(0, 15)));
				run_random(150);
				drain_results();
				run_random(170);
			end
			default: begin
				send_idle_pct = 19;
				recv_stall_pct = 19;
				program_bank(16'hFFFF, 16'd0, 16'($urandom_range(1, 5)),
					16'($urandom_range(1, 5)), 4'b0101);
				run_random(320);
			end
			endcase
			drain_results();
		end
		repeat (5) @(posedge clk);
		if (bank.mismatches == 0 && bank.expected_status.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
